// File: rtl/lipc_pkg.sv
// lipc_pkg: shared types, codes and helper functions of the interrupt priority controller
`timescale 1ns / 1ps

package lipc_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned N_WORDS = 4;
    localparam int unsigned BIT_W   = $clog2(WORD_W);
    localparam int unsigned WIDX_W  = $clog2(N_WORDS);
    localparam int unsigned VEC_W   = 8;
    localparam int unsigned CODE_W  = 6;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned IN_W    = 88;
    localparam int unsigned OUT_W   = 24;

    localparam logic [VEC_W-1:0]  SPURIOUS_CODE = 8'd15;
    localparam logic [VEC_W-1:0]  VEC_NMI       = 8'd2;
    localparam logic [VEC_W-1:0]  VEC_EXT       = 8'd0;
    localparam logic [CODE_W-1:0] CODE_NONE     = 6'd0;
    localparam logic [CODE_W-1:0] CODE_NMI      = 6'd32;
    localparam logic [CODE_W-1:0] CODE_EXT      = 6'd16;

    typedef enum logic [3:0] {
        CMD_PEND   = 4'd0,
        CMD_BATCH  = 4'd1,
        CMD_UNPEND = 4'd2,
        CMD_CHECK  = 4'd3,
        CMD_READ   = 4'd4,
        CMD_EOI    = 4'd5,
        CMD_WPRI   = 4'd6,
        CMD_DETECT = 4'd7,
        CMD_QUERY  = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    typedef enum logic [1:0] {
        MASK_NONE,
        MASK_TPR,
        MASK_INSVC
    } mask_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  psr_slot;
        logic               psr_collect;
        logic               psr_enable;
        logic               mask_all;
        logic [CLASS_W-1:0] priority_class;
        logic [WORD_W-1:0]  batch_mask;
        logic [WIDX_W-1:0]  word_index;
        logic [VEC_W-1:0]   vector;
        logic [3:0]         command;
    } item_t;

    // index of the highest set bit, zero for an empty word
    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (w[b])
            begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

    // priority code of a selected vector
    function automatic logic [CODE_W-1:0] code_of(input logic found, input logic [VEC_W-1:0] v);
        logic [CODE_W-1:0] c;
        if (!found)
        begin
            c = CODE_NONE;
        end
        else if (v == VEC_NMI)
        begin
            c = CODE_NMI;
        end
        else if (v == VEC_EXT)
        begin
            c = CODE_EXT;
        end
        else
        begin
            c = CODE_W'(v[VEC_W-1:4]);
        end
        return c;
    endfunction

endpackage

// File: rtl/local_interrupt_priority_controller.sv
// local_interrupt_priority_controller: command sequencer, vector bit sets and result register
`timescale 1ns / 1ps

// Local interrupt controller holding 256 pending and 256 in-service vector bits, a task
// priority (class plus mask-all bit) and a highest-priority code. Each command beat on the
// slave stream yields exactly one result beat on the master stream. The block works on one
// command at a time: pend, batch, unpend, write priority and detect go from accept straight
// to the final step; eoi scans the in-service set and check, read ivr and query scan both sets;
// the highest vector of each 256-bit set is found by one shared 64-bit priority encoder that
// steps through the four words of a set, one word per cycle (NMI, vector 2, and ExtINT,
// vector 0, outrank the highest set bit). A new command is accepted while the previous
// result still waits in the output register; the sequencer stalls in its final step only
// when that register is still full. notify_enable is written through cfg_we / cfg_wdata and
// should only change while the block is idle.
module local_interrupt_priority_controller
    import lipc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration: notify_enable
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    // command stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // command[3:0], vector[11:4], word_index[13:12], batch_mask[77:14],
    // priority_class[81:78], mask_all[82], psr_enable[83], psr_collect[84], psr_slot[86:85]
    input  logic [IN_W-1:0]  s_tdata,
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // vector_out[7:0], spurious[8], deliver[9], slot_out[11:10], error[12], was_set[13],
    // new_pending[14], priority_code[20:15], notify[21], unmasked[22]
    output logic [OUT_W-1:0] m_tdata
);

    // architectural state
    logic [WORD_W-1:0]  pend_reg  [N_WORDS];
    logic [WORD_W-1:0]  insvc_reg [N_WORDS];
    logic [CLASS_W-1:0] mask_class_reg, mask_class_next;
    logic               mask_all_reg, mask_all_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic               notify_en_reg;

    // sequencer
    state_t             state_reg, state_next;
    item_t              item_reg;
    cmd_t               cmd;
    logic               scan_set_reg, scan_set_next;     // 0 pending, 1 in service
    logic [WIDX_W-1:0]  scan_word_reg, scan_word_next;
    logic               hp_found_reg, hp_found_next;
    logic [VEC_W-1:0]   hp_vec_reg, hp_vec_next;
    logic               hi_found_reg, hi_found_next;
    logic [VEC_W-1:0]   hi_vec_reg, hi_vec_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;

    logic               s_fire, m_fire, exec_done, out_block;
    logic               needs_scan, starts_insvc;

    // shared read port and priority encoder
    logic [WIDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_word;
    logic               enc_any;
    logic [BIT_W-1:0]   enc_idx;
    logic               cur_found;
    logic [VEC_W-1:0]   cur_vec;
    logic               scan_found;
    logic [VEC_W-1:0]   scan_vec;

    // update requests from the final step
    logic               pend_we, insvc_we;
    logic [WIDX_W-1:0]  pend_addr, insvc_addr;
    logic [WORD_W-1:0]  pend_set, pend_clr, insvc_set, insvc_clr;

    // result fields
    logic [VEC_W-1:0]   r_vector;
    logic               r_spurious, r_deliver, r_error, r_was_set, r_new_pending;
    logic               r_notify, r_unmasked;
    logic [SLOT_W-1:0]  r_slot;
    logic [OUT_W-1:0]   result;

    mask_t              mstate;
    logic [WORD_W-1:0]  vec_bit, hp_bit, hi_bit;
    logic [CODE_W-1:0]  threshold;
    logic [4:0]         limit;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign out_block = out_valid_reg && !m_tready;
    assign exec_done = (state_reg == ST_EXEC) && !out_block;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cmd       = cmd_t'(item_reg.command);

    // which commands need the set scans, decoded at accept
    always_comb
    begin
        needs_scan   = 1'b0;
        starts_insvc = 1'b0;
        unique case (s_tdata[3:0]) inside
            CMD_CHECK, CMD_READ, CMD_QUERY:
            begin
                needs_scan = 1'b1;
            end
            CMD_EOI:
            begin
                needs_scan   = 1'b1;
                starts_insvc = 1'b1;
            end
            default:
            begin
                needs_scan = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                if (scan_word_reg == '0 && scan_set_reg)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_block)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shared read port: scan word during a scan, the command's word otherwise
    assign rd_addr = (state_reg == ST_SCAN) ? scan_word_reg
                                            : item_reg.vector[VEC_W-1:BIT_W];
    assign rd_word = (state_reg == ST_SCAN && scan_set_reg) ? insvc_reg[rd_addr]
                                                            : pend_reg[rd_addr];
    assign enc_any = |rd_word;
    assign enc_idx = top_bit(rd_word);

    assign cur_found = scan_set_reg ? hi_found_reg : hp_found_reg;
    assign cur_vec   = scan_set_reg ? hi_vec_reg : hp_vec_reg;

    // one scan step: words go from the top down, word 0 checks nmi and extint first
    always_comb
    begin
        scan_found = cur_found;
        scan_vec   = cur_vec;
        if (scan_word_reg == '0 && rd_word[VEC_NMI[BIT_W-1:0]])
        begin
            scan_found = 1'b1;
            scan_vec   = VEC_NMI;
        end
        else if (scan_word_reg == '0 && rd_word[VEC_EXT[BIT_W-1:0]])
        begin
            scan_found = 1'b1;
            scan_vec   = VEC_EXT;
        end
        else if (!cur_found && enc_any)
        begin
            scan_found = 1'b1;
            scan_vec   = {scan_word_reg, enc_idx};
        end
    end

    // scan bookkeeping
    always_comb
    begin
        scan_set_next  = scan_set_reg;
        scan_word_next = scan_word_reg;
        hp_found_next  = hp_found_reg;
        hp_vec_next    = hp_vec_reg;
        hi_found_next  = hi_found_reg;
        hi_vec_next    = hi_vec_reg;
        if (s_fire)
        begin
            scan_set_next  = starts_insvc;
            scan_word_next = WIDX_W'(N_WORDS - 1);
            hp_found_next  = 1'b0;
            hi_found_next  = 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (scan_set_reg)
            begin
                hi_found_next = scan_found;
                hi_vec_next   = scan_vec;
            end
            else
            begin
                hp_found_next = scan_found;
                hp_vec_next   = scan_vec;
            end
            scan_word_next = scan_word_reg - 1'b1;
            if (scan_word_reg == '0)
            begin
                scan_set_next = 1'b1;
            end
        end
    end

    // masking of the highest pending vector against in-service vector and task priority
    always_comb
    begin
        limit = {mask_all_reg, mask_class_reg};
        if (hi_found_reg && hi_vec_reg == VEC_NMI)
        begin
            mstate = MASK_INSVC;
        end
        else if (hp_found_reg && hp_vec_reg == VEC_NMI)
        begin
            mstate = MASK_NONE;
        end
        else if (hi_found_reg && hi_vec_reg == VEC_EXT)
        begin
            mstate = MASK_INSVC;
        end
        else if (hp_found_reg && hp_vec_reg == VEC_EXT)
        begin
            mstate = mask_all_reg ? MASK_TPR : MASK_NONE;
        end
        else if (hp_found_reg && (!hi_found_reg || hp_vec_reg > hi_vec_reg))
        begin
            mstate = ({1'b0, hp_vec_reg[VEC_W-1:4]} > limit) ? MASK_NONE : MASK_TPR;
        end
        else
        begin
            mstate = MASK_INSVC;
        end
    end

    assign vec_bit   = WORD_W'(1) << item_reg.vector[BIT_W-1:0];
    assign hp_bit    = WORD_W'(1) << hp_vec_reg[BIT_W-1:0];
    assign hi_bit    = WORD_W'(1) << hi_vec_reg[BIT_W-1:0];
    assign threshold = {~item_reg.psr_enable, mask_all_reg, mask_class_reg};

    // final step: result fields and state updates
    always_comb
    begin
        r_vector        = '0;
        r_spurious      = 1'b0;
        r_deliver       = 1'b0;
        r_slot          = '0;
        r_error         = 1'b0;
        r_was_set       = 1'b0;
        r_new_pending   = 1'b0;
        r_notify        = 1'b0;
        r_unmasked      = 1'b0;
        code_next       = code_reg;
        mask_class_next = mask_class_reg;
        mask_all_next   = mask_all_reg;
        pend_we         = 1'b0;
        insvc_we        = 1'b0;
        pend_addr       = item_reg.vector[VEC_W-1:BIT_W];
        insvc_addr      = hi_vec_reg[VEC_W-1:BIT_W];
        pend_set        = '0;
        pend_clr        = '0;
        insvc_set       = '0;
        insvc_clr       = '0;
        unique case (cmd)
            CMD_PEND:
            begin
                r_was_set     = rd_word[item_reg.vector[BIT_W-1:0]];
                r_new_pending = !r_was_set;
                pend_we       = 1'b1;
                pend_set      = vec_bit;
            end
            CMD_BATCH:
            begin
                r_new_pending = 1'b1;
                pend_we       = 1'b1;
                pend_addr     = item_reg.word_index;
                pend_set      = item_reg.batch_mask;
            end
            CMD_UNPEND:
            begin
                r_was_set     = rd_word[item_reg.vector[BIT_W-1:0]];
                r_new_pending = r_was_set;
                pend_we       = 1'b1;
                pend_clr      = vec_bit;
            end
            CMD_CHECK:
            begin
                if (!hp_found_reg)
                begin
                    code_next  = CODE_NONE;
                    r_notify   = notify_en_reg;
                    r_vector   = SPURIOUS_CODE;
                    r_spurious = 1'b1;
                end
                else
                begin
                    r_vector = hp_vec_reg;
                    if (item_reg.psr_enable && mstate == MASK_NONE)
                    begin
                        code_next = code_of(1'b1, hp_vec_reg);
                        r_notify  = notify_en_reg;
                        if (item_reg.psr_collect)
                        begin
                            r_deliver = 1'b1;
                            r_slot    = item_reg.psr_slot;
                        end
                        else
                        begin
                            r_error = 1'b1;
                        end
                    end
                    else if (mstate == MASK_INSVC)
                    begin
                        if (code_reg != CODE_NONE)
                        begin
                            code_next = CODE_NONE;
                            r_notify  = notify_en_reg;
                        end
                    end
                    else
                    begin
                        code_next = code_of(1'b1, hp_vec_reg);
                        r_notify  = notify_en_reg;
                    end
                end
            end
            CMD_READ:
            begin
                if (!hp_found_reg || mstate == MASK_INSVC)
                begin
                    if (code_reg != CODE_NONE)
                    begin
                        code_next = CODE_NONE;
                        r_notify  = notify_en_reg;
                    end
                    r_vector   = SPURIOUS_CODE;
                    r_spurious = 1'b1;
                end
                else if (mstate == MASK_TPR)
                begin
                    code_next  = code_of(1'b1, hp_vec_reg);
                    r_notify   = notify_en_reg;
                    r_vector   = SPURIOUS_CODE;
                    r_spurious = 1'b1;
                end
                else
                begin
                    // acknowledge: move the vector from pending to in service
                    insvc_we      = 1'b1;
                    insvc_addr    = hp_vec_reg[VEC_W-1:BIT_W];
                    insvc_set     = hp_bit;
                    pend_we       = 1'b1;
                    pend_addr     = hp_vec_reg[VEC_W-1:BIT_W];
                    pend_clr      = hp_bit;
                    r_vector      = hp_vec_reg;
                    r_new_pending = 1'b1;
                end
            end
            CMD_EOI:
            begin
                if (!hi_found_reg)
                begin
                    r_error = 1'b1;
                end
                else
                begin
                    insvc_we      = 1'b1;
                    insvc_clr     = hi_bit;
                    r_new_pending = 1'b1;
                end
            end
            CMD_WPRI:
            begin
                mask_class_next = item_reg.priority_class;
                mask_all_next   = item_reg.mask_all;
            end
            CMD_DETECT:
            begin
                if (code_reg > threshold)
                begin
                    r_unmasked = 1'b1;
                    if (item_reg.psr_collect)
                    begin
                        r_deliver = 1'b1;
                        r_slot    = item_reg.psr_slot;
                    end
                    else
                    begin
                        r_error = 1'b1;
                    end
                end
            end
            CMD_QUERY:
            begin
                r_unmasked = hp_found_reg && (mstate == MASK_NONE);
            end
            default:
            begin
                // unknown commands only report the current code
                r_unmasked = 1'b0;
            end
        endcase
    end

    assign result = {1'b0, r_unmasked, r_notify, code_next, r_new_pending, r_was_set,
                     r_error, r_slot, r_deliver, r_spurious, r_vector};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            scan_set_reg   <= 1'b0;
            scan_word_reg  <= '0;
            hp_found_reg   <= 1'b0;
            hi_found_reg   <= 1'b0;
            mask_class_reg <= '0;
            mask_all_reg   <= 1'b1;
            code_reg       <= CODE_NONE;
            notify_en_reg  <= 1'b0;
            for (int i = 0; i < N_WORDS; i++)
            begin
                pend_reg[i]  <= '0;
                insvc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scan_set_reg  <= scan_set_next;
            scan_word_reg <= scan_word_next;
            hp_found_reg  <= hp_found_next;
            hi_found_reg  <= hi_found_next;
            if (cfg_we)
            begin
                notify_en_reg <= cfg_wdata;
            end
            if (exec_done)
            begin
                mask_class_reg <= mask_class_next;
                mask_all_reg   <= mask_all_next;
                code_reg       <= code_next;
                // each word applies its own set and clear masks
                for (int i = 0; i < N_WORDS; i++)
                begin
                    if (pend_we && pend_addr == WIDX_W'(i))
                    begin
                        pend_reg[i] <= (pend_reg[i] | pend_set) & ~pend_clr;
                    end
                    if (insvc_we && insvc_addr == WIDX_W'(i))
                    begin
                        insvc_reg[i] <= (insvc_reg[i] | insvc_set) & ~insvc_clr;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hp_vec_reg <= hp_vec_next;
        hi_vec_reg <= hi_vec_next;
        if (s_fire)
        begin
            item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
        if (exec_done)
        begin
            out_data_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    // one command at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("command accepted while the sequencer was busy");

    // the final step always leaves a result in the output register
    a_exec_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        exec_done |=> m_tvalid)
        else $error("final step did not produce a result beat");

    // the code is none, a vector class, extint or nmi
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (code_reg <= CODE_EXT) || (code_reg == CODE_NMI))
        else $error("priority code out of range");

    // a scan only ever runs for check, read ivr, query or eoi
    a_scan_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cmd == CMD_CHECK || cmd == CMD_READ ||
                                    cmd == CMD_QUERY || cmd == CMD_EOI))
        else $error("set scan started for a command that needs none");
`endif

endmodule

// File: sim/tb_local_interrupt_priority_controller.sv
// tb_local_interrupt_priority_controller: self-checking stream testbench of the controller
`timescale 1ns / 1ps

module tb_local_interrupt_priority_controller;
    import lipc_pkg::*;

    // result fields, last field in the lowest bits as on m_tdata
    typedef struct packed {
        logic              unmasked;
        logic              notify;
        logic [CODE_W-1:0] priority_code;
        logic              new_pending;
        logic              was_set;
        logic              error;
        logic [SLOT_W-1:0] slot_out;
        logic              deliver;
        logic              spurious;
        logic [VEC_W-1:0]  vector_out;
    } ctl_result_t;

    localparam int unsigned ITEM_W = $bits(item_t);
    localparam int unsigned RES_W  = $bits(ctl_result_t);

    // command codes past the last defined one do nothing
    localparam logic [3:0] CMD_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

    localparam int NMI_VEC = int'(VEC_NMI);
    localparam int EXT_VEC = int'(VEC_EXT);
    localparam int NO_VEC  = -1;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 20;
    localparam int IDLE_PCT    = 13;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // controller state as the checker sees it
    logic [255:0]       pending_set    = '0;
    logic [255:0]       in_service_set = '0;
    logic [CLASS_W-1:0] class_now      = '0;
    logic               mask_all_now   = 1'b1;
    logic [CODE_W-1:0]  code_now       = CODE_NONE;
    logic               notify_on      = 1'b0;

    item_t       cmd_queue[$];
    ctl_result_t expected_results[$];

    logic        cmd_taken   = 1'b0;
    logic        quiet       = 1'b0;
    int          fault_count = 0;
    int          cycle_count = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    ctl_result_t got_result;
    ctl_result_t want_result;
    ctl_result_t next_result;
    item_t       taken_item;
    logic [IN_W-1:0] beat_bits;

    local_interrupt_priority_controller u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // nmi, then extint, then the highest set bit
    function automatic int top_vector(input logic [255:0] set);
        if (set[NMI_VEC])
        begin
            return NMI_VEC;
        end
        if (set[EXT_VEC])
        begin
            return EXT_VEC;
        end
        for (int v = 255; v >= 0; v--)
        begin
            if (set[v])
            begin
                return v;
            end
        end
        return NO_VEC;
    endfunction

    function automatic logic [CODE_W-1:0] code_for(input int v);
        if (v == NO_VEC)
        begin
            return CODE_NONE;
        end
        if (v == NMI_VEC)
        begin
            return CODE_NMI;
        end
        if (v == EXT_VEC)
        begin
            return CODE_EXT;
        end
        return CODE_W'(v >> 4);
    endfunction

    // highest pending against highest in service and the task priority
    function automatic mask_t mask_verdict(input int hp, input int hi);
        int limit;
        limit = int'(class_now) + (mask_all_now ? 16 : 0);
        if (hi == NMI_VEC)
        begin
            return MASK_INSVC;
        end
        if (hp == NMI_VEC)
        begin
            return MASK_NONE;
        end
        if (hi == EXT_VEC)
        begin
            return MASK_INSVC;
        end
        if (hp == EXT_VEC)
        begin
            return mask_all_now ? MASK_TPR : MASK_NONE;
        end
        if (hp > hi || (hp != NO_VEC && hi == NO_VEC))
        begin
            return (hp >= 0 && (hp >> 4) > limit) ? MASK_NONE : MASK_TPR;
        end
        return MASK_INSVC;
    endfunction

    // apply one command to the state copy and return its result beat
    task automatic predict_result(input item_t it, output ctl_result_t r);
        int               hp;
        int               hi;
        mask_t            verdict;
        logic             code_written;
        logic [CODE_W-1:0] threshold;
        r = '0;
        code_written = 1'b0;
        hp = top_vector(pending_set);
        hi = top_vector(in_service_set);
        verdict = mask_verdict(hp, hi);
        case (it.command)
            CMD_PEND:
            begin
                r.was_set = pending_set[it.vector];
                pending_set[it.vector] = 1'b1;
                r.new_pending = !r.was_set;
            end
            CMD_BATCH:
            begin
                pending_set[{it.word_index, 6'd0} +: WORD_W] =
                    pending_set[{it.word_index, 6'd0} +: WORD_W] | it.batch_mask;
                r.new_pending = 1'b1;
            end
            CMD_UNPEND:
            begin
                r.was_set = pending_set[it.vector];
                pending_set[it.vector] = 1'b0;
                r.new_pending = r.was_set;
            end
            CMD_CHECK:
            begin
                if (hp == NO_VEC)
                begin
                    code_now = CODE_NONE;
                    code_written = 1'b1;
                    r.vector_out = SPURIOUS_CODE;
                    r.spurious = 1'b1;
                end
                else
                begin
                    r.vector_out = VEC_W'(hp);
                    if (it.psr_enable && verdict == MASK_NONE)
                    begin
                        code_now = code_for(hp);
                        code_written = 1'b1;
                        // collection off turns the delivery into an error
                        if (it.psr_collect)
                        begin
                            r.deliver = 1'b1;
                            r.slot_out = it.psr_slot;
                        end
                        else
                        begin
                            r.error = 1'b1;
                        end
                    end
                    else if (verdict == MASK_INSVC)
                    begin
                        if (code_now != CODE_NONE)
                        begin
                            code_now = CODE_NONE;
                            code_written = 1'b1;
                        end
                    end
                    else
                    begin
                        code_now = code_for(hp);
                        code_written = 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                if (hp == NO_VEC || verdict == MASK_INSVC)
                begin
                    if (code_now != CODE_NONE)
                    begin
                        code_now = CODE_NONE;
                        code_written = 1'b1;
                    end
                    r.vector_out = SPURIOUS_CODE;
                    r.spurious = 1'b1;
                end
                else if (verdict == MASK_TPR)
                begin
                    code_now = code_for(hp);
                    code_written = 1'b1;
                    r.vector_out = SPURIOUS_CODE;
                    r.spurious = 1'b1;
                end
                else
                begin
                    in_service_set[hp] = 1'b1;
                    pending_set[hp] = 1'b0;
                    r.vector_out = VEC_W'(hp);
                    r.new_pending = 1'b1;
                end
            end
            CMD_EOI:
            begin
                if (hi == NO_VEC)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    in_service_set[hi] = 1'b0;
                    r.new_pending = 1'b1;
                end
            end
            CMD_WPRI:
            begin
                class_now = it.priority_class;
                mask_all_now = it.mask_all;
            end
            CMD_DETECT:
            begin
                threshold = {!it.psr_enable, mask_all_now, class_now};
                if (code_now > threshold)
                begin
                    r.unmasked = 1'b1;
                    if (it.psr_collect)
                    begin
                        r.deliver = 1'b1;
                        r.slot_out = it.psr_slot;
                    end
                    else
                    begin
                        r.error = 1'b1;
                    end
                end
            end
            CMD_QUERY:
            begin
                r.unmasked = (hp != NO_VEC && verdict == MASK_NONE);
            end
            default:
            begin
            end
        endcase
        r.priority_code = code_now;
        r.notify = code_written && notify_on;
    endtask

    // random content around a fixed command
    function automatic item_t blank_item(input logic [3:0] cmd);
        item_t it;
        int    pick;
        it.command = cmd;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            it.vector = VEC_EXT;
        end
        else if (pick == 1)
        begin
            it.vector = VEC_NMI;
        end
        else if (pick == 2)
        begin
            it.vector = 8'hFF;
        end
        else
        begin
            it.vector = VEC_W'($urandom_range(255));
        end
        it.word_index = WIDX_W'($urandom_range(N_WORDS - 1));
        // mostly sparse masks so the pending set does not saturate
        pick = $urandom_range(15);
        if (pick == 0)
        begin
            it.batch_mask = '1;
        end
        else if (pick == 1)
        begin
            it.batch_mask = {$urandom, $urandom};
        end
        else
        begin
            it.batch_mask = 64'd1 << $urandom_range(WORD_W - 1);
        end
        it.priority_class = CLASS_W'($urandom_range(15));
        it.mask_all = ($urandom_range(3) == 0);
        it.psr_enable = ($urandom_range(99) < 80);
        it.psr_collect = ($urandom_range(99) < 85);
        it.psr_slot = SLOT_W'($urandom_range(3));
        return it;
    endfunction

    function automatic item_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            return blank_item(CMD_PEND);
        end
        if (pick < 21)
        begin
            return blank_item(CMD_BATCH);
        end
        if (pick < 34)
        begin
            return blank_item(CMD_UNPEND);
        end
        if (pick < 46)
        begin
            return blank_item(CMD_CHECK);
        end
        if (pick < 61)
        begin
            return blank_item(CMD_READ);
        end
        if (pick < 73)
        begin
            return blank_item(CMD_EOI);
        end
        if (pick < 81)
        begin
            return blank_item(CMD_WPRI);
        end
        if (pick < 89)
        begin
            return blank_item(CMD_DETECT);
        end
        if (pick < 97)
        begin
            return blank_item(CMD_QUERY);
        end
        return blank_item(4'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)));
    endfunction

    task automatic queue_cmd(input logic [3:0] cmd, input logic [VEC_W-1:0] vec,
                             input logic en, input logic col);
        item_t it;
        it = blank_item(cmd);
        it.vector = vec;
        it.psr_enable = en;
        it.psr_collect = col;
        cmd_queue.push_back(it);
    endtask

    task automatic queue_priority(input logic [CLASS_W-1:0] cls, input logic all_bit);
        item_t it;
        it = blank_item(CMD_WPRI);
        it.priority_class = cls;
        it.mask_all = all_bit;
        cmd_queue.push_back(it);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            cmd_queue.push_back(random_item());
        end
    endtask

    // every command sent, every result back
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_notify(input logic value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        notify_on = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // command driver, moves on after each accepted beat
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || cmd_taken))
        begin
            if (cmd_queue.size() != 0 && !(!quiet && $urandom_range(99) < IDLE_PCT))
            begin
                beat_bits = '0;
                beat_bits[ITEM_W-1:0] = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= beat_bits;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and requested long hold-offs
    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_served != hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= rst_n && !(!quiet && $urandom_range(99) < IDLE_PCT);
        end
    end

    // check result beats, then predict for the command beat taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_result = ctl_result_t'(m_tdata[RES_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    fault_count = fault_count + 1;
                    if (fault_count <= 10)
                    begin
                        $display("unexpected result beat %h at cycle %0d", m_tdata, cycle_count);
                    end
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.vector_out !== want_result.vector_out
                        || got_result.spurious !== want_result.spurious
                        || got_result.deliver !== want_result.deliver
                        || got_result.slot_out !== want_result.slot_out
                        || got_result.error !== want_result.error
                        || got_result.was_set !== want_result.was_set
                        || got_result.new_pending !== want_result.new_pending
                        || got_result.priority_code !== want_result.priority_code
                        || got_result.notify !== want_result.notify
                        || got_result.unmasked !== want_result.unmasked)
                    begin
                        fault_count = fault_count + 1;
                        if (fault_count <= 10)
                        begin
                            $display("result mismatch at cycle %0d", cycle_count);
                            $display("  expected vec=%0d spur=%0d dlv=%0d slot=%0d err=%0d",
                                want_result.vector_out, want_result.spurious,
                                want_result.deliver, want_result.slot_out,
                                want_result.error,
                                " set=%0d new=%0d code=%0d ntf=%0d unm=%0d",
                                want_result.was_set,
                                want_result.new_pending, want_result.priority_code,
                                want_result.notify, want_result.unmasked);
                            $display("  actual   vec=%0d spur=%0d dlv=%0d slot=%0d err=%0d",
                                got_result.vector_out, got_result.spurious,
                                got_result.deliver, got_result.slot_out,
                                got_result.error,
                                " set=%0d new=%0d code=%0d ntf=%0d unm=%0d",
                                got_result.was_set,
                                got_result.new_pending, got_result.priority_code,
                                got_result.notify, got_result.unmasked);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken_item = item_t'(s_tdata[ITEM_W-1:0]);
                predict_result(taken_item, next_result);
                expected_results.push_back(next_result);
            end
            cmd_taken = s_tvalid && s_tready;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_notify(1'b1);

        // empty sets: spurious paths, eoi error, nothing to detect
        queue_cmd(CMD_QUERY, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_CHECK, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_READ, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_EOI, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_DETECT, 8'd0, 1'b1, 1'b1);
        // nmi, extint and the top vector, then a repeated pend
        queue_cmd(CMD_PEND, VEC_NMI, 1'b1, 1'b1);
        queue_cmd(CMD_PEND, VEC_EXT, 1'b1, 1'b1);
        queue_cmd(CMD_PEND, 8'hFF, 1'b1, 1'b1);
        queue_cmd(CMD_PEND, 8'hFF, 1'b1, 1'b1);
        queue_priority(4'd0, 1'b0);
        // delivery with collection off
        queue_cmd(CMD_CHECK, 8'd0, 1'b1, 1'b0);
        queue_cmd(CMD_DETECT, 8'd0, 1'b1, 1'b1);
        // nmi in service masks extint, eoi releases it
        queue_cmd(CMD_READ, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_READ, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_EOI, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_READ, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_QUERY, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_EOI, 8'd0, 1'b1, 1'b1);
        begin
            item_t it;
            it = blank_item(CMD_BATCH);
            it.word_index = 2'd3;
            it.batch_mask = '1;
            cmd_queue.push_back(it);
        end
        queue_cmd(CMD_UNPEND, 8'hFF, 1'b1, 1'b1);
        queue_cmd(CMD_UNPEND, 8'hFF, 1'b1, 1'b1);
        queue_cmd(CMD_CHECK, 8'd0, 1'b1, 1'b1);
        // mask everything external: read is held off by the priority
        queue_priority(4'd15, 1'b1);
        queue_cmd(CMD_READ, 8'd0, 1'b1, 1'b1);
        queue_cmd(CMD_DETECT, 8'd0, 1'b0, 1'b1);
        queue_cmd(CMD_UNUSED_LAST, 8'd0, 1'b1, 1'b1);
        wait_drained();

        write_notify(1'b0);
        queue_random(500);
        wait_drained();

        // no idling on either side
        write_notify(1'b1);
        quiet = 1'b1;
        queue_random(500);
        wait_drained();
        quiet = 1'b0;

        // receiver holds off while commands keep coming
        hold_requests = hold_requests + 1;
        queue_random(50);
        wait_drained();

        write_notify(1'b0);
        queue_random(500);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fault_count == 0 && expected_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
